[src/rxrb_pkg.sv]
// Shared types and constants for the receive ring buffer with line detection.
package rxrb_pkg;

    localparam int unsigned DEPTH_DEF = 256;
    localparam logic [7:0] DELIM_RESET = 8'd10;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_LINE  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        LS_NONE     = 2'd0,
        LS_FOUND    = 2'd1,
        LS_OVERFLOW = 2'd2
    } t_line_status;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_POP  = 2'd1,
        ST_SCAN = 2'd2
    } t_state;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        logic [7:0]   read_byte;
        logic         read_valid;
        logic         read_is_delimiter;
        logic [7:0]   bytes_available;
        t_line_status line_status;
        logic [7:0]   line_length;
        logic         overflow_flag;
    } t_result;

endpackage

[src/rx_ring_buffer_line_detect.sv]
// Top level: receive ring buffer with line detection.
// Push, clear and a query answered without a scan pass the command queue and the
// result queue registers; a pop also passes the byte store read register; a line
// scan examines k entries (up to DEPTH-1), one per cycle on the single read port.
// One push or clear per cycle while results drain; a pop passes through ST_POP.
// Reset (i_rst_n low, synchronous) empties both queues, zeroes the indices and
// the overflow flag and sets the delimiter to 10; the byte store is not cleared.
module rx_ring_buffer_line_detect import rxrb_pkg::*; #(
    parameter int unsigned DEPTH = DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] i_op,
    input  logic [7:0] i_rx_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_read_byte,
    output logic       o_read_valid,
    output logic       o_read_is_delimiter,
    output logic [7:0] o_bytes_available,
    output logic [1:0] o_line_status,
    output logic [7:0] o_line_length,
    output logic       o_overflow_flag,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data
);

    logic    w_cmd_valid, w_cmd_take, w_res_valid, w_res_full;
    t_cmd    w_cmd;
    t_result w_res, w_head;

    rxrb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_op        (i_op),
        .i_rx_byte   (i_rx_byte),
        .o_full      (full),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_take  (w_cmd_take)
    );

    rxrb_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd_valid   (w_cmd_valid),
        .i_cmd         (w_cmd),
        .o_cmd_take    (w_cmd_take),
        .i_res_full    (w_res_full),
        .o_res_valid   (w_res_valid),
        .o_res         (w_res)
    );

    rxrb_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .o_full      (w_res_full),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_res       (w_head)
    );

    assign o_read_byte         = w_head.read_byte;
    assign o_read_valid        = w_head.read_valid;
    assign o_read_is_delimiter = w_head.read_is_delimiter;
    assign o_bytes_available   = w_head.bytes_available;
    assign o_line_status       = w_head.line_status;
    assign o_line_length       = w_head.line_length;
    assign o_overflow_flag     = w_head.overflow_flag;

endmodule

[src/rxrb_front.sv]
// Front end: decodes incoming requests and holds them in a two-entry command queue.
module rxrb_front import rxrb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [1:0] i_op,
    input  logic [7:0] i_rx_byte,
    output logic       o_full,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd,
    input  logic       i_cmd_take
);

    t_cmd       r_slot [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       n_wp, n_rp;
    logic [1:0] n_cnt;
    t_cmd       w_cmd;
    logic       w_in, w_out;

    // only a push carries a byte; the rest go down with a zeroed payload
    always_comb begin
        w_cmd.op   = t_op'(i_op);
        w_cmd.data = (t_op'(i_op) == OP_PUSH) ? i_rx_byte : 8'd0;
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_slot[r_rp];
    assign w_in        = i_push && !o_full;
    assign w_out       = i_cmd_take && o_cmd_valid;

    always_comb begin
        n_wp  = w_in  ? !r_wp : r_wp;
        n_rp  = w_out ? !r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, w_in} - {1'b0, w_out};
    end

    always_ff @(posedge i_clk) begin
        if (w_in) begin
            r_slot[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

[src/rxrb_back.sv]
// Back end: byte store, ring indices, overflow flag and the line scan sequencer.
module rxrb_back import rxrb_pkg::*; #(
    parameter int unsigned DEPTH = DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_take,
    input  logic       i_res_full,
    output logic       o_res_valid,
    output t_result    o_res
);

    localparam int unsigned AW = $clog2(DEPTH);

    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rdata;
    logic [AW-1:0] r_wr_idx, n_wr_idx;
    logic [AW-1:0] r_rd_idx, n_rd_idx;
    logic [AW-1:0] r_count, n_count;
    logic [AW-1:0] r_scan_idx, n_scan_idx;
    logic [AW-1:0] r_scan_n, n_scan_n;
    logic          r_ovf, n_ovf;
    logic [7:0]    r_delim;
    t_state        r_state, n_state;

    logic          w_mem_we;
    logic [AW-1:0] w_rd_addr;
    logic [AW-1:0] w_seen;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
        return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    // counts reach the result as 8 bits: zero-extend or keep the low byte
    function automatic logic [7:0] to_byte(input logic [AW-1:0] c);
        logic [AW+7:0] e;
        e = {8'd0, c};
        return e[7:0];
    endfunction

    assign w_seen = r_scan_n + 1'b1;

    always_comb begin
        n_state     = r_state;
        n_wr_idx    = r_wr_idx;
        n_rd_idx    = r_rd_idx;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_scan_idx  = r_scan_idx;
        n_scan_n    = r_scan_n;
        w_mem_we    = 1'b0;
        w_rd_addr   = r_rd_idx;
        o_cmd_take  = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && !i_res_full) begin
                    o_cmd_take  = 1'b1;
                    o_res_valid = 1'b1;
                    case (i_cmd.op)
                        OP_PUSH: begin
                            if (r_count == AW'(DEPTH - 1)) begin
                                n_ovf = 1'b1;
                            end else begin
                                w_mem_we = 1'b1;
                                n_wr_idx = next_slot(r_wr_idx);
                                n_count  = r_count + 1'b1;
                            end
                        end
                        OP_POP: begin
                            if (r_count != '0) begin
                                o_res_valid = 1'b0;
                                n_state     = ST_POP;
                            end
                        end
                        OP_LINE: begin
                            if (r_ovf) begin
                                o_res.line_status = LS_OVERFLOW;
                            end else if (r_count != '0) begin
                                o_res_valid = 1'b0;
                                n_scan_idx  = r_rd_idx;
                                n_scan_n    = '0;
                                n_state     = ST_SCAN;
                            end
                        end
                        OP_CLEAR: begin
                            n_wr_idx = '0;
                            n_rd_idx = '0;
                            n_count  = '0;
                            n_ovf    = 1'b0;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_POP: begin
                o_res_valid             = 1'b1;
                o_res.read_byte         = r_rdata;
                o_res.read_valid        = 1'b1;
                o_res.read_is_delimiter = (r_rdata == r_delim);
                n_rd_idx                = next_slot(r_rd_idx);
                n_count                 = r_count - 1'b1;
                n_state                 = ST_IDLE;
            end
            ST_SCAN: begin
                // r_rdata holds the entry at r_scan_idx
                if (r_rdata == r_delim) begin
                    o_res_valid       = 1'b1;
                    o_res.line_status = LS_FOUND;
                    o_res.line_length = to_byte(w_seen);
                    n_state           = ST_IDLE;
                end else if (w_seen == r_count) begin
                    o_res_valid = 1'b1;
                    n_state     = ST_IDLE;
                end else begin
                    n_scan_idx = next_slot(r_scan_idx);
                    n_scan_n   = w_seen;
                    w_rd_addr  = next_slot(r_scan_idx);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        o_res.bytes_available = to_byte(n_count);
        o_res.overflow_flag   = n_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_wr_idx] <= i_cmd.data;
        end
        r_rdata <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_wr_idx   <= '0;
            r_rd_idx   <= '0;
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_scan_idx <= '0;
            r_scan_n   <= '0;
            r_delim    <= DELIM_RESET;
        end else begin
            r_state    <= n_state;
            r_wr_idx   <= n_wr_idx;
            r_rd_idx   <= n_rd_idx;
            r_count    <= n_count;
            r_ovf      <= n_ovf;
            r_scan_idx <= n_scan_idx;
            r_scan_n   <= n_scan_n;
            if (i_cfg_wr_en) begin
                r_delim <= i_cfg_wr_data;
            end
        end
    end

endmodule

[src/rxrb_out.sv]
// Two-entry result queue between the back end and the consumer.
module rxrb_out import rxrb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_valid,
    input  t_result i_res,
    output logic    o_full,
    output logic    o_empty,
    input  logic    i_pop,
    output t_result o_res
);

    t_result    r_slot [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       n_wp, n_rp;
    logic [1:0] n_cnt;
    logic       w_in, w_out;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_res   = r_slot[r_rp];
    assign w_in    = i_res_valid && !o_full;
    assign w_out   = i_pop && !o_empty;

    always_comb begin
        n_wp  = w_in  ? !r_wp : r_wp;
        n_rp  = w_out ? !r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, w_in} - {1'b0, w_out};
    end

    always_ff @(posedge i_clk) begin
        if (w_in) begin
            r_slot[r_wp] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

[src/rxrb_chk.sv]
// Port-level checker for the receive ring buffer, bound to the top level.
module rxrb_chk import rxrb_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_read_byte,
    input logic       o_read_valid,
    input logic       o_read_is_delimiter,
    input logic [7:0] o_bytes_available,
    input logic [1:0] o_line_status,
    input logic [7:0] o_line_length,
    input logic       o_overflow_flag
);

    // nothing waits on the result side straight after reset
    a_empty_after_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // a result that is not a returned byte carries no byte and no delimiter mark
    a_no_byte_without_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_read_valid) |-> (o_read_byte == 8'd0 && !o_read_is_delimiter))
        else $error("byte fields set without read_valid");

    // an overflow status is only reported together with the sticky flag
    a_ovf_status_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_line_status == LS_OVERFLOW) |-> o_overflow_flag)
        else $error("overflow status without overflow flag");

    // a line length appears only with a found line
    a_len_only_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_line_status != LS_FOUND) |-> (o_line_length == 8'd0))
        else $error("line length without found line");

    // a result not taken stays on the ports
    a_head_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_read_byte) && $stable(o_bytes_available)))
        else $error("waiting result changed");

endmodule

bind rx_ring_buffer_line_detect rxrb_chk u_chk (.*);
